FILE: hw/rtl/itrt_pkg.sv
// shared constants for the integer to radix text converter
// no dependencies; imported by integer_to_radix_text

package itrt_pkg;

    // default sizing of the converter
    localparam int MAX_BASE_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // widths fixed by the item and register layout
    localparam int IN_W      = 32;
    localparam int CHAR_W    = 8;
    localparam int SYM_COUNT = 16;
    localparam int CFG_W     = 64;
    localparam int RADIX_W   = 5;
    localparam int ADDR_W    = 5;

    // quotient bits retired per divider cycle
    localparam int DIV_CHUNK = 8;

    // characters the alphabet may not contain
    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'd32;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_SYMBOLS_LOW  = 2'd0,
        REG_SYMBOLS_HIGH = 2'd1,
        REG_RADIX_COUNT  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

endpackage

FILE: hw/rtl/integer_to_radix_text.sv
// integer to radix text converter, top level
// depends on itrt_pkg for constants and the register index type
//
// usage:
//   s_ channel: one signed value per request in s_tdata[31:0]; only the low
//   VALUE_BITS bits are used as a two's complement number
//   m_ channel: one character per request, most significant digit first,
//   a minus sign ahead of negative values; m_tlast marks the final character,
//   m_tuser flags an invalid alphabet (one request with character 0, tlast 1)
//   apb port: symbols_low at 0x00, symbols_high at 0x08, radix_count at 0x10;
//   write only while the block is idle
// timing:
//   the magnitude is divided by the radix in a shared divider that retires
//   8 quotient bits per cycle, so each digit costs ceil(VALUE_BITS/8) cycles
//   (4 at 32 bits); then one character leaves per cycle while m_tready is high
//   item time ~ 2 + digits*ceil(VALUE_BITS/8) + characters, 128 + 35 worst case
//   (radix 2, most negative value); s_tready is high only between items
// reset: registers clear to zero, so every value gives the error request
// stall: a held m_ request freezes character output; the next value is taken
// as soon as the final character sits in the output register

module integer_to_radix_text
    import itrt_pkg::*;
#(
    parameter int MAX_BASE   = MAX_BASE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // value request
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [31:0] value
    // character request
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,   // [7:0] character
    output logic               m_tlast,
    output logic               m_tuser,   // [0] bad_alphabet
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int DIGW      = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
    localparam int DIV_STEPS = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int DW        = DIV_STEPS * DIV_CHUNK;
    localparam int SW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int IW        = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ERROR,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        symbols_low_reg;
    logic [CFG_W-1:0]        symbols_high_reg;
    logic [RADIX_W-1:0]      radix_count_reg;
    logic                    alpha_ok_reg;
    logic                    neg_reg;
    logic                    sign_pending_reg;
    logic [DW-1:0]           shift_reg;
    logic [DIGW-1:0]         rem_reg;
    logic [SW-1:0]           step_reg;
    logic [IW-1:0]           nd_reg;
    logic [IW-1:0]           ptr_reg;
    logic [DIGW-1:0]         digit_mem [VALUE_BITS];
    logic                    m_tvalid_reg;
    logic [CHAR_W-1:0]       m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    m_tuser_reg;

    logic [CHAR_W-1:0]       sym [SYM_COUNT];
    logic                    alpha_ok;
    logic [VALUE_BITS-1:0]   raw;
    logic [VALUE_BITS-1:0]   mag;
    logic [DIGW:0]           radix_cmp;
    logic [DIGW-1:0]         rem_next;
    logic [DIV_CHUNK-1:0]    qbits;
    logic [DW+DIV_CHUNK-1:0] shift_cat;
    logic [DW-1:0]           shift_next;
    logic                    out_free;
    logic                    out_load;
    logic                    cfg_write;
    reg_index_t              cfg_index;
    logic [CHAR_W-1:0]       emit_char;

    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[4:3]);
    assign pready    = 1'b1;

    always_comb begin
        unique case (cfg_index)
            REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            REG_RADIX_COUNT:  prdata = CFG_W'(radix_count_reg);
            default:          prdata = '0;
        endcase
    end

    for (genvar g = 0; g < SYM_COUNT / 2; g++) begin : g_sym
        assign sym[g]                 = symbols_low_reg[g*CHAR_W +: CHAR_W];
        assign sym[g + SYM_COUNT / 2] = symbols_high_reg[g*CHAR_W +: CHAR_W];
    end

    // alphabet check, registered; the user must change the config only while idle; the block does not enforce it
    always_comb begin
        logic in_use;
        logic [CHAR_W-1:0] c;
        alpha_ok = (radix_count_reg >= RADIX_W'(2)) &&
                   (radix_count_reg <= RADIX_W'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++) begin
            in_use = RADIX_W'(i) < radix_count_reg;
            c      = sym[i];
            if (in_use && (c == CHAR_NUL || c == CHAR_MINUS || c == CHAR_PLUS ||
                           (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE)) begin
                alpha_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
                if (in_use && (RADIX_W'(j) < radix_count_reg) && sym[j] == c) begin
                    alpha_ok = 1'b0;
                end
            end
        end
    end

    // two's complement magnitude; the most negative value maps onto itself
    assign raw = s_tdata[VALUE_BITS-1:0];
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // shared divider: eight restoring steps per cycle on the narrow remainder
    assign radix_cmp = radix_count_reg[DIGW:0];

    always_comb begin
        logic [DIGW:0] t;
        logic [DIGW-1:0] r;
        logic [DIV_CHUNK-1:0] chunk;
        r     = rem_reg;
        chunk = shift_reg[DW-1 -: DIV_CHUNK];
        qbits = '0;
        for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
            t = {r, chunk[k]};
            if (t >= radix_cmp) begin
                t        = t - radix_cmp;
                qbits[k] = 1'b1;
            end
            r = t[DIGW-1:0];
        end
        rem_next = r;
    end

    assign shift_cat  = {shift_reg, qbits};
    assign shift_next = shift_cat[DW-1:0];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == ST_ERROR) || (state_reg == ST_EMIT));
    assign emit_char = sym[4'(digit_mem[ptr_reg])];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
            radix_count_reg  <= '0;
            alpha_ok_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            alpha_ok_reg <= alpha_ok;

            if (cfg_write) begin
                unique case (cfg_index)
                    REG_SYMBOLS_LOW:  symbols_low_reg  <= pwdata;
                    REG_SYMBOLS_HIGH: symbols_high_reg <= pwdata;
                    REG_RADIX_COUNT:  radix_count_reg  <= pwdata[RADIX_W-1:0];
                    default:          ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        neg_reg   <= raw[VALUE_BITS-1];
                        shift_reg <= DW'(mag);
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        nd_reg    <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= alpha_ok_reg ? ST_DIVIDE : ST_ERROR;
                end
                ST_ERROR: begin
                    if (out_free) begin
                        m_tdata_reg  <= CHAR_NUL;
                        m_tlast_reg  <= 1'b1;
                        m_tuser_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_DIVIDE: begin
                    shift_reg <= shift_next;
                    if (step_reg == SW'(DIV_STEPS - 1)) begin
                        // digit complete, remainder is the digit value
                        digit_mem[nd_reg] <= rem_next;
                        nd_reg            <= nd_reg + IW'(1);
                        rem_reg           <= '0;
                        step_reg          <= '0;
                        if (shift_next == '0) begin
                            ptr_reg          <= nd_reg;
                            sign_pending_reg <= neg_reg;
                            state_reg        <= ST_EMIT;
                        end
                    end else begin
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tuser_reg  <= 1'b0;
                        if (sign_pending_reg) begin
                            m_tdata_reg      <= CHAR_MINUS;
                            m_tlast_reg      <= 1'b0;
                            sign_pending_reg <= 1'b0;
                        end else begin
                            m_tdata_reg <= emit_char;
                            m_tlast_reg <= (ptr_reg == '0);
                            if (ptr_reg == '0) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                ptr_reg <= ptr_reg - IW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: bench/integer_to_radix_text_tb.sv
// self-checking bench for integer_to_radix_text: directed and random values in set and random alphabets,
// predicted text checked character by character on the m_ channel
// depends on itrt_pkg and the integer_to_radix_text rtl

module integer_to_radix_text_tb;
    import itrt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RAND_PHASES  = 12;
    localparam int unsigned PHASE_VALUES = 28;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_alphabet;
    } text_char_t;

    // ways to spoil an alphabet
    typedef enum int unsigned {
        FLAW_NONE, FLAW_FEW, FLAW_MANY, FLAW_MINUS, FLAW_PLUS,
        FLAW_CTRL, FLAW_SPACE, FLAW_NUL, FLAW_REPEAT
    } flaw_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;   // [31:0] value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;         // [7:0] character
    logic               m_tlast;
    logic               m_tuser;         // [0] bad_alphabet
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [CFG_W-1:0]   pwdata   = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    // shadow of the register file
    logic [CFG_W-1:0]   sym_lo  = '0;
    logic [CFG_W-1:0]   sym_hi  = '0;
    logic [RADIX_W-1:0] radix_q = '0;

    logic [CHAR_W-1:0]  alpha [SYM_COUNT];
    logic [IN_W-1:0]    values_to_send [$];
    text_char_t         chars_due [$];
    text_char_t         due_char;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    int unsigned hold_left      = 0;
    bit          hold_start     = 1'b0;
    bit          no_idle        = 1'b0;

    integer_to_radix_text dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] sym_of(int unsigned idx);
        if (idx < 8) begin
            return sym_lo[8*idx +: 8];
        end
        return sym_hi[8*(idx-8) +: 8];
    endfunction

    function automatic bit byte_allowed(logic [CHAR_W-1:0] b);
        return !(b == CHAR_NUL || b == CHAR_MINUS || b == CHAR_PLUS || b == CHAR_SPACE ||
                 (b >= CHAR_TAB && b <= CHAR_CR));
    endfunction

    function automatic bit alphabet_valid();
        int unsigned n;
        n = 32'(radix_q);
        if (n < 2 || n > MAX_BASE_DEF) begin
            return 1'b0;
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (!byte_allowed(sym_of(i))) begin
                return 1'b0;
            end
            for (int unsigned j = i + 1; j < n; j++) begin
                if (sym_of(j) == sym_of(i)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // queue up the characters that one value turns into
    function automatic void render_value(logic [IN_W-1:0] v);
        int unsigned       mag;
        int unsigned       radix;
        int unsigned       nd;
        logic [CHAR_W-1:0] digits [VALUE_BITS_DEF];
        text_char_t        c;
        c.bad_alphabet = 1'b0;
        if (!alphabet_valid()) begin
            c.character    = CHAR_NUL;
            c.last         = 1'b1;
            c.bad_alphabet = 1'b1;
            chars_due.push_back(c);
            return;
        end
        radix = 32'(radix_q);
        // two's complement negate also covers the most negative value
        mag = v[IN_W-1] ? (~v + 1) : v;
        nd  = 0;
        if (mag == 0) begin
            digits[0] = sym_of(0);
            nd = 1;
        end
        while (mag != 0 && nd < VALUE_BITS_DEF) begin
            digits[nd] = sym_of(mag % radix);
            mag = mag / radix;
            nd++;
        end
        if (v[IN_W-1]) begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            chars_due.push_back(c);
        end
        for (int unsigned k = nd; k > 0; k--) begin
            c.character = digits[k-1];
            c.last      = (k == 1);
            chars_due.push_back(c);
        end
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_W-1:0] random_value();
        int unsigned     r;
        logic [IN_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = '1;
                2: v = 32'd1;
                3: v = 32'h7fff_ffff;
                default: v = 32'h8000_0000;
            endcase
        end else if (r < 35) begin
            v = $urandom_range(0, 300);
            if ($urandom_range(0, 1)) v = -v;
        end else if (r < 60) begin
            v = $urandom;
        end else begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
        end
        return v;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic apb_write(reg_index_t idx, logic [CFG_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SYMBOLS_LOW:  sym_lo  = data;
            REG_SYMBOLS_HIGH: sym_hi  = data;
            REG_RADIX_COUNT:  radix_q = data[RADIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_alphabet(int unsigned radix);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] cnt;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = alpha[i];
            hi[8*i +: 8] = alpha[i+8];
        end
        // junk above the count field must be dropped
        cnt = {$urandom, $urandom};
        cnt[RADIX_W-1:0] = RADIX_W'(radix);
        apb_write(REG_SYMBOLS_LOW, lo);
        apb_write(REG_SYMBOLS_HIGH, hi);
        apb_write(REG_RADIX_COUNT, cnt);
    endtask

    task automatic set_alphabet(int unsigned radix, flaw_t flaw);
        int unsigned       p;
        int unsigned       q;
        logic [CHAR_W-1:0] b;
        bit                fresh;
        for (int i = 0; i < SYM_COUNT; i++) begin
            do begin
                b = CHAR_W'($urandom_range(0, 255));
                fresh = byte_allowed(b);
                for (int j = 0; j < i; j++) begin
                    if (alpha[j] == b) fresh = 1'b0;
                end
            end while (!fresh);
            alpha[i] = b;
        end
        // symbols past the count may hold anything
        for (int i = radix; i < SYM_COUNT; i++) begin
            if ($urandom_range(0, 1)) alpha[i] = CHAR_W'($urandom_range(0, 255));
        end
        p = $urandom_range(0, radix - 1);
        case (flaw)
            FLAW_FEW:    radix = 1;
            FLAW_MANY:   radix = $urandom_range(0, 2) == 0 ? 31 : $urandom_range(17, 30);
            FLAW_MINUS:  alpha[p] = CHAR_MINUS;
            FLAW_PLUS:   alpha[p] = CHAR_PLUS;
            FLAW_CTRL: begin
                case ($urandom_range(0, 2))
                    0: alpha[p] = CHAR_TAB;
                    1: alpha[p] = CHAR_CR;
                    default: alpha[p] = CHAR_W'($urandom_range(CHAR_TAB + 1, CHAR_CR - 1));
                endcase
            end
            FLAW_SPACE:  alpha[p] = CHAR_SPACE;
            FLAW_NUL:    alpha[p] = CHAR_NUL;
            FLAW_REPEAT: begin
                q = (p + $urandom_range(1, radix - 1)) % radix;
                alpha[q] = alpha[p];
            end
            default: ;
        endcase
        load_alphabet(radix);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (values_to_send.size() != 0 || s_tvalid || chars_due.size() != 0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // value driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) render_value(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (values_to_send.size() != 0) begin
                    s_tdata  <= values_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= no_idle ? 0 : gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // character monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (chars_due.size() == 0) begin
                    flag_mismatch("character with nothing pending", 32'(m_tdata), 0);
                end else begin
                    due_char = chars_due.pop_front();
                    if (m_tdata !== due_char.character)
                        flag_mismatch("character", 32'(m_tdata), 32'(due_char.character));
                    if (m_tlast !== due_char.last)
                        flag_mismatch("tlast", 32'(m_tlast), 32'(due_char.last));
                    if (m_tuser !== due_char.bad_alphabet)
                        flag_mismatch("bad_alphabet", 32'(m_tuser),
                                      32'(due_char.bad_alphabet));
                end
            end
            if (hold_start) begin
                hold_start <= 1'b0;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                recv_stall <= gap_len();
                m_tready   <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** integer_to_radix_text: FAILED **");
            $finish;
        end
    end

    initial begin
        flaw_t       flaw_list [9];
        int unsigned radix;
        int unsigned r;
        flaw_list = '{FLAW_FEW, FLAW_MANY, FLAW_MINUS, FLAW_PLUS, FLAW_CTRL, FLAW_CTRL,
                      FLAW_SPACE, FLAW_NUL, FLAW_REPEAT};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // alphabet still cleared by reset
        values_to_send.push_back(32'd0);
        values_to_send.push_back(32'h8000_0000);
        wait_idle();

        // decimal digits, zero bytes in the unused slots
        for (int i = 0; i < SYM_COUNT; i++) alpha[i] = (i < 10) ? CHAR_W'(8'h30 + i) : CHAR_NUL;
        load_alphabet(10);
        apb_write(REG_UNUSED, {$urandom, $urandom});
        @(negedge aclk);
        values_to_send.push_back(32'd0);
        values_to_send.push_back(32'hffff_ffff);
        values_to_send.push_back(32'h7fff_ffff);
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'd10);
        wait_idle();

        // binary, longest texts
        load_alphabet(2);
        @(negedge aclk);
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'h7fff_ffff);
        wait_idle();

        // extreme symbol bytes
        for (int i = 0; i < SYM_COUNT; i++) alpha[i] = CHAR_W'(8'h41 + i);
        alpha[0]  = 8'h01;
        alpha[15] = 8'hff;
        load_alphabet(16);
        @(negedge aclk);
        values_to_send.push_back(32'd0);
        values_to_send.push_back(32'hffff_ffff);
        wait_idle();

        foreach (flaw_list[i]) begin
            set_alphabet(10, flaw_list[i]);
            @(negedge aclk);
            values_to_send.push_back(random_value());
            wait_idle();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            r = $urandom_range(0, 3);
            radix = (r == 0) ? 2 : (r == 1) ? 16 : $urandom_range(3, 15);
            if ($urandom_range(0, 5) == 0)
                set_alphabet(radix, flaw_t'($urandom_range(FLAW_FEW, FLAW_REPEAT)));
            else
                set_alphabet(radix, FLAW_NONE);
            @(negedge aclk);
            no_idle <= (ph % 4 == 3);
            // receiver goes quiet while requests keep coming
            if (ph == 5) hold_start <= 1'b1;
            for (int i = 0; i < PHASE_VALUES; i++) values_to_send.push_back(random_value());
            wait_idle();
        end

        no_idle <= 1'b0;
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** integer_to_radix_text: PASSED **");
        end else begin
            $display("** integer_to_radix_text: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/itrt_pkg.sv
hw/rtl/integer_to_radix_text.sv
bench/integer_to_radix_text_tb.sv
